>>> rtl/huffman_tree_walk_decoder_defines.svh
// Assertion macros shared by the decoder checker.
// No dependencies; included by files that assert.
`ifndef HUFFMAN_TREE_WALK_DECODER_DEFINES_SVH
`define HUFFMAN_TREE_WALK_DECODER_DEFINES_SVH

// check cons in the same cycle as ante
`define HTWD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// check cons in the cycle after ante
`define HTWD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/htwd_pkg.sv
// Shared types and constants of the tree-walk decoder.
// No dependencies; imported by the interfaces, the RAM user and the checker.
package htwd_pkg;

  localparam int NODE_COUNT = 511;
  localparam int RAM_AW     = $clog2(NODE_COUNT);
  localparam int IDX_W      = 9;
  localparam int SYM_W      = 8;
  localparam int OP_W       = 2;
  localparam int BYTE_W     = 8;
  localparam int ENTRY_W    = 1 + SYM_W + 2 * IDX_W;
  localparam int BIT_CNT_W  = $clog2(BYTE_W + 1);
  localparam int DATA_W     = 32;
  localparam int CFG_AW     = 3;
  localparam int CFG_IDX_W  = CFG_AW - 2;

  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_COUNT = CFG_IDX_W'(0);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_DECODE  = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  typedef struct packed {
    logic             is_leaf;
    logic [SYM_W-1:0] symbol;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } node_entry_t;

endpackage

>>> rtl/htwd_if.sv
// Valid/ready channels of the tree-walk decoder: command items and result items.
// Depends on htwd_pkg for field widths.
interface htwd_cmd_if import htwd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [IDX_W-1:0]  node_index;
  logic              node_is_leaf;
  logic [SYM_W-1:0]  node_symbol;
  logic [IDX_W-1:0]  left_child;
  logic [IDX_W-1:0]  right_child;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, operation, node_index, node_is_leaf, node_symbol,
                  left_child, right_child, data_byte, input ready);
  modport sink (input valid, operation, node_index, node_is_leaf, node_symbol,
                left_child, right_child, data_byte, output ready);
endinterface

interface htwd_res_if import htwd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             symbol_valid;
  logic             last;
  logic             finished;

  modport source (output valid, symbol, symbol_valid, last, finished, input ready);
  modport sink (input valid, symbol, symbol_valid, last, finished, output ready);
endinterface

>>> rtl/htwd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module htwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/huffman_tree_walk_decoder.sv
// Tree-walk decoder top level. Depends on htwd_pkg, htwd_if and htwd_ram.
// Load, restart and unused codes: one result registered one cycle after accept.
// Decode: one node-memory read per code bit, up to eight bits per byte; the walk
// resolves the last read, then S_FLUSH ends the item; stalled results hold it.
// Reset (synchronous) clears walk, count, finished flag and expected_count;
// the node memory is not cleared and no clearing pass runs.
module huffman_tree_walk_decoder import htwd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  htwd_cmd_if.sink          cmd,
  htwd_res_if.source        res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FLUSH
  } state_t;

  state_t               state;
  logic [DATA_W-1:0]    expected_count;
  logic [DATA_W-1:0]    decoded_count;
  logic [DATA_W-1:0]    count_next;
  logic                 done;
  node_entry_t          cur_entry;
  node_entry_t          root_entry;
  node_entry_t          rd_entry;
  node_entry_t          eff_entry;
  node_entry_t          load_entry;
  logic [IDX_W-1:0]     walk_pos;
  logic [IDX_W-1:0]     pend_addr;
  logic [IDX_W-1:0]     issue_addr;
  logic                 pend;
  logic                 rd_oob;
  logic [BYTE_W-1:0]    shreg;
  logic [BIT_CNT_W-1:0] bits_left;
  logic                 hold_v;
  logic [SYM_W-1:0]     hold_sym;
  logic                 hold_fin;
  logic                 o_valid;
  logic [SYM_W-1:0]     o_sym;
  logic                 o_sv;
  logic                 o_last;
  logic                 o_fin;
  logic                 out_free;
  logic                 accept;
  op_t                  op;
  logic                 leaf_hit;
  logic                 stall;
  logic                 done_hit;
  logic                 walk_end;
  logic                 issue;
  logic                 ram_we;
  logic [ENTRY_W-1:0]   ram_rdata;
  logic                 cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[CFG_AW-1:2] == REG_EXPECTED_COUNT);
  assign prdata = (paddr[CFG_AW-1:2] == REG_EXPECTED_COUNT) ? expected_count : '0;

  assign out_free  = !o_valid || res.ready;
  assign cmd.ready = (state == S_IDLE) && out_free;
  assign accept    = cmd.valid && cmd.ready;
  assign op        = op_t'(cmd.operation);

  assign res.valid        = o_valid;
  assign res.symbol       = o_sym;
  assign res.symbol_valid = o_sv;
  assign res.last         = o_last;
  assign res.finished     = o_fin;

  assign load_entry = '{is_leaf: cmd.node_is_leaf, symbol: cmd.node_symbol,
                        left: cmd.left_child, right: cmd.right_child};
  assign ram_we = accept && (op == OP_LOAD) && (cmd.node_index < IDX_W'(NODE_COUNT));

  assign rd_entry   = rd_oob ? '0 : node_entry_t'(ram_rdata);
  assign leaf_hit   = (state == S_WALK) && pend && rd_entry.is_leaf;
  assign stall      = leaf_hit && hold_v && !out_free;
  assign count_next = decoded_count + DATA_W'(1);
  assign done_hit   = leaf_hit && (expected_count != '0) && (count_next == expected_count);
  assign eff_entry  = !pend ? cur_entry : (rd_entry.is_leaf ? root_entry : rd_entry);
  assign walk_end   = done_hit || (bits_left == '0);
  assign issue      = (state == S_WALK) && !stall && !walk_end;
  assign issue_addr = shreg[0] ? eff_entry.right : eff_entry.left;

  htwd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cmd.node_index[RAM_AW-1:0]),
    .wdata (load_entry),
    .re    (issue),
    .raddr (issue_addr[RAM_AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      expected_count <= '0;
      decoded_count  <= '0;
      done           <= 1'b0;
      walk_pos       <= '0;
      pend           <= 1'b0;
      hold_v         <= 1'b0;
      o_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        expected_count <= pwdata;
      end
      if (res.ready) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            o_valid <= 1'b1;
            o_sym   <= '0;
            o_sv    <= 1'b0;
            o_last  <= 1'b1;
            o_fin   <= done;
            case (op)
              OP_LOAD: begin
                if (ram_we && (cmd.node_index == '0)) begin
                  root_entry <= load_entry;
                end
                if (ram_we && (cmd.node_index == walk_pos)) begin
                  cur_entry <= load_entry;
                end
              end
              OP_RESTART: begin
                walk_pos      <= '0;
                decoded_count <= '0;
                done          <= 1'b0;
                cur_entry     <= root_entry;
                o_fin         <= 1'b0;
              end
              OP_DECODE: begin
                if (!done) begin
                  o_valid   <= 1'b0;
                  shreg     <= cmd.data_byte;
                  bits_left <= BIT_CNT_W'(BYTE_W);
                  pend      <= 1'b0;
                  state     <= S_WALK;
                end
              end
              default: ;
            endcase
          end
        end
        S_WALK: begin
          if (!stall) begin
            if (pend) begin
              if (rd_entry.is_leaf) begin
                decoded_count <= count_next;
                done          <= done_hit;
                walk_pos      <= '0;
                if (hold_v) begin
                  o_valid <= 1'b1;
                  o_sym   <= hold_sym;
                  o_sv    <= 1'b1;
                  o_last  <= 1'b0;
                  o_fin   <= hold_fin;
                end
                hold_v   <= 1'b1;
                hold_sym <= rd_entry.symbol;
                hold_fin <= done_hit;
              end else begin
                walk_pos <= pend_addr;
              end
            end
            cur_entry <= eff_entry;
            if (walk_end) begin
              pend  <= 1'b0;
              state <= S_FLUSH;
            end else begin
              pend      <= 1'b1;
              pend_addr <= issue_addr;
              rd_oob    <= issue_addr >= IDX_W'(NODE_COUNT);
              shreg     <= shreg >> 1;
              bits_left <= bits_left - BIT_CNT_W'(1);
            end
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            o_valid <= 1'b1;
            o_last  <= 1'b1;
            if (hold_v) begin
              o_sym  <= hold_sym;
              o_sv   <= 1'b1;
              o_fin  <= hold_fin;
              hold_v <= 1'b0;
            end else begin
              o_sym <= '0;
              o_sv  <= 1'b0;
              o_fin <= done;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/htwd_checker.sv
// Port-level checks of the tree-walk decoder, bound to the top level.
// Depends on htwd_pkg and huffman_tree_walk_decoder_defines.svh.
`include "huffman_tree_walk_decoder_defines.svh"

module htwd_checker import htwd_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             cmd_valid,
  input logic             cmd_ready,
  input logic [OP_W-1:0]  cmd_operation,
  input logic             res_valid,
  input logic             res_ready,
  input logic [SYM_W-1:0] res_symbol,
  input logic             res_symbol_valid,
  input logic             res_last,
  input logic             res_finished
);

  `HTWD_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res_symbol) && $stable(res_last) && $stable(res_finished), "stalled result item changed")
  `HTWD_ASSERT_NOW(a_empty_last, clk, rst, res_valid && !res_symbol_valid, res_last && (res_symbol == '0), "empty result item is not last or carries a symbol")
  `HTWD_ASSERT_NOW(a_ready_idle, clk, rst, cmd_ready, !res_valid || res_last, "command taken while results of an item are pending")
  `HTWD_ASSERT_NEXT(a_quick_result, clk, rst, cmd_valid && cmd_ready && (cmd_operation != OP_DECODE), res_valid && res_last && !res_symbol_valid, "non-decode item gave no result next cycle")

endmodule

bind huffman_tree_walk_decoder htwd_checker u_htwd_checker (
  .clk              (clk),
  .rst              (rst),
  .cmd_valid        (cmd.valid),
  .cmd_ready        (cmd.ready),
  .cmd_operation    (cmd.operation),
  .res_valid        (res.valid),
  .res_ready        (res.ready),
  .res_symbol       (res.symbol),
  .res_symbol_valid (res.symbol_valid),
  .res_last         (res.last),
  .res_finished     (res.finished)
);
